FILE: hw/rtl/orient_insphere_predicate_macros.svh
// assertion macros shared by the orient / insphere predicate rtl
`ifndef ORIENT_INSPHERE_PREDICATE_MACROS_SVH
`define ORIENT_INSPHERE_PREDICATE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define OIP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("orient_insphere_predicate: check failed");
// next-cycle implication, checked out of reset
`define OIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("orient_insphere_predicate: check failed");
`else
`define OIP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define OIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/oip_pkg.sv
// shared constants and types of the orient / insphere predicate unit
package oip_pkg;

  // packed point width on the ports
  localparam int PT_W           = 48;
  localparam int COORD_BITS_DEF = 16;
  // limb width of the split final multiply
  localparam int LIMB_BITS      = 24;

  // result sign codes
  localparam logic [1:0] SIGN_NEG  = 2'b11;
  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;

  // operation select
  localparam logic FUNC_INSPHERE = 1'b1;

  // control that travels with each word down the pipeline
  typedef struct packed {
    logic vld;
    logic func;
  } tag_t;

endpackage

FILE: hw/rtl/oip_minor.sv
// stages 1-2: difference vectors, 2x2 minors and squared lengths
`include "orient_insphere_predicate_macros.svh"
module oip_minor import oip_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  tag_t                          tag_i,
  input  logic [PT_W-1:0]               pt_i [5],
  output tag_t                          tag_o,
  output logic signed [COORD_BITS:0]    b_o [3],
  output logic signed [COORD_BITS:0]    c_o [3],
  output logic signed [2*COORD_BITS+2:0] minor_o [3][3],
  output logic signed [2*COORD_BITS+2:0] norm_o [4]
);

  localparam int CB     = COORD_BITS;
  localparam int DW     = CB + 1;
  localparam int MW     = 2*CB + 3;
  localparam int PACK_W = (3*CB > PT_W) ? 3*CB : PT_W;

  // vector pairs for the minors: (d,e), (c,e), (c,d); b=0 c=1 d=2 e=3
  localparam int PAIR_V [3] = '{2, 1, 1};
  localparam int PAIR_T [3] = '{3, 3, 2};

  logic [PACK_W-1:0]    pk [5];
  logic signed [DW-1:0] dif_nxt [4][3];
  logic signed [DW-1:0] dif_r [4][3];
  logic signed [MW-1:0] minor_nxt [3][3];
  logic signed [MW-1:0] minor_r [3][3];
  logic signed [MW-1:0] norm_nxt [4];
  logic signed [MW-1:0] norm_r [4];
  logic signed [DW-1:0] b_r [3];
  logic signed [DW-1:0] c_r [3];
  tag_t                 tag1_r;
  tag_t                 tag2_r;

  // p*q - r*s
  function automatic logic signed [MW-1:0] cross_m(
    input logic signed [DW-1:0] p,
    input logic signed [DW-1:0] q,
    input logic signed [DW-1:0] r,
    input logic signed [DW-1:0] s
  );
    logic signed [2*DW-1:0] pq;
    logic signed [2*DW-1:0] rs;
    pq = p * q;
    rs = r * s;
    return MW'(pq) - MW'(rs);
  endfunction

  // x*x + y*y + z*z
  function automatic logic signed [MW-1:0] sq_sum(
    input logic signed [DW-1:0] x,
    input logic signed [DW-1:0] y,
    input logic signed [DW-1:0] z
  );
    logic signed [2*DW-1:0] xx;
    logic signed [2*DW-1:0] yy;
    logic signed [2*DW-1:0] zz;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    return MW'(xx) + MW'(yy) + MW'(zz);
  endfunction

  // widen the packed points so every coordinate field exists
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      pk[i] = PACK_W'(pt_i[i]);
    end
  end

  // difference vectors against point a
  always_comb begin
    for (int v = 0; v < 4; v++) begin
      for (int k = 0; k < 3; k++) begin
        dif_nxt[v][k] = DW'(signed'(pk[v+1][k*CB +: CB]))
                      - DW'(signed'(pk[0][k*CB +: CB]));
      end
    end
  end

  // minors of the three vector pairs and the squared lengths
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      minor_nxt[p][0] = cross_m(dif_r[PAIR_V[p]][1], dif_r[PAIR_T[p]][2],
                                dif_r[PAIR_V[p]][2], dif_r[PAIR_T[p]][1]);
      minor_nxt[p][1] = cross_m(dif_r[PAIR_V[p]][0], dif_r[PAIR_T[p]][2],
                                dif_r[PAIR_V[p]][2], dif_r[PAIR_T[p]][0]);
      minor_nxt[p][2] = cross_m(dif_r[PAIR_V[p]][0], dif_r[PAIR_T[p]][1],
                                dif_r[PAIR_V[p]][1], dif_r[PAIR_T[p]][0]);
    end
    for (int v = 0; v < 4; v++) begin
      norm_nxt[v] = sq_sum(dif_r[v][0], dif_r[v][1], dif_r[v][2]);
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else if (en) begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      dif_r   <= dif_nxt;
      minor_r <= minor_nxt;
      norm_r  <= norm_nxt;
      b_r     <= dif_r[0];
      c_r     <= dif_r[1];
    end
  end

  assign tag_o   = tag2_r;
  assign b_o     = b_r;
  assign c_o     = c_r;
  assign minor_o = minor_r;
  assign norm_o  = norm_r;

endmodule

FILE: hw/rtl/oip_det.sv
// stages 3-4: the four 3x3 determinants by cofactor expansion
`include "orient_insphere_predicate_macros.svh"
module oip_det import oip_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  tag_t                           tag_i,
  input  logic signed [COORD_BITS:0]     b_i [3],
  input  logic signed [COORD_BITS:0]     c_i [3],
  input  logic signed [2*COORD_BITS+2:0] minor_i [3][3],
  input  logic signed [2*COORD_BITS+2:0] norm_i [4],
  output tag_t                           tag_o,
  output logic signed [3*COORD_BITS+5:0] det_o [4],
  output logic signed [2*COORD_BITS+2:0] norm_o [4]
);

  localparam int CB  = COORD_BITS;
  localparam int MW  = 2*CB + 3;
  localparam int PW  = 3*CB + 4;
  localparam int DTW = 3*CB + 6;

  logic signed [PW-1:0]  prod_nxt [4][3];
  logic signed [PW-1:0]  prod_r [4][3];
  logic signed [DTW-1:0] det_nxt [4];
  logic signed [DTW-1:0] det_r [4];
  logic signed [MW-1:0]  norm3_r [4];
  logic signed [MW-1:0]  norm4_r [4];
  tag_t                  tag3_r;
  tag_t                  tag4_r;

  // row times minor: det(c,d,e), det(b,d,e), det(b,c,e), det(b,c,d)
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_nxt[0][k] = c_i[k] * minor_i[0][k];
      prod_nxt[1][k] = b_i[k] * minor_i[0][k];
      prod_nxt[2][k] = b_i[k] * minor_i[1][k];
      prod_nxt[3][k] = b_i[k] * minor_i[2][k];
    end
  end

  // alternating sum of the cofactor terms
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      det_nxt[d] = DTW'(prod_r[d][0]) - DTW'(prod_r[d][1]) + DTW'(prod_r[d][2]);
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag3_r <= '0;
      tag4_r <= '0;
    end else if (en) begin
      tag3_r <= tag_i;
      tag4_r <= tag3_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      det_r   <= det_nxt;
      norm3_r <= norm_i;
      norm4_r <= norm3_r;
    end
  end

  assign tag_o  = tag4_r;
  assign det_o  = det_r;
  assign norm_o = norm4_r;

  // a stalled pipeline keeps its words in place
  `OIP_ASSERT_NEXT(a_det_hold, clk, rst_n, !en, $stable(tag4_r) && $stable(tag3_r))

endmodule

FILE: hw/rtl/oip_scale.sv
// stages 5-8: length-weighted determinant sum in limbs (or the orientation determinant), then the sign
`include "orient_insphere_predicate_macros.svh"
module oip_scale import oip_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  tag_t                           tag_i,
  input  logic signed [3*COORD_BITS+5:0] det_i [4],
  input  logic signed [2*COORD_BITS+2:0] norm_i [4],
  output tag_t                           tag_o,
  output logic [1:0]                     sign_o
);

  localparam int CB  = COORD_BITS;
  localparam int NW  = 2*CB + 3;
  localparam int DTW = 3*CB + 6;
  localparam int LB  = LIMB_BITS;
  localparam int NL  = (DTW + LB - 1) / LB;
  localparam int XW  = NL * LB;
  localparam int PPW = NW + LB + 1;
  localparam int TW  = NW + DTW;
  localparam int RW  = TW + 2;

  logic signed [XW-1:0]  det_ext [4];
  logic signed [LB:0]    limb [4][NL];
  logic signed [PPW-1:0] pp_nxt [4][NL];
  logic signed [PPW-1:0] pp_r [4][NL];
  logic signed [TW-1:0]  term_nxt [4];
  logic signed [TW-1:0]  term_r [4];
  logic signed [RW-1:0]  val_nxt;
  logic signed [RW-1:0]  val_r;
  logic [1:0]            sign_nxt;
  logic [1:0]            sign_r;
  logic signed [DTW-1:0] ori5_r;
  logic signed [DTW-1:0] ori6_r;
  tag_t                  tag5_r;
  tag_t                  tag6_r;
  tag_t                  tag7_r;
  tag_t                  tag8_r;

  // cut each determinant into limbs: unsigned low limbs, signed top limb
  always_comb begin
    for (int t = 0; t < 4; t++) begin
      det_ext[t] = XW'(det_i[t]);
      for (int i = 0; i < NL; i++) begin
        if (i == NL - 1) begin
          limb[t][i] = {det_ext[t][XW-1], det_ext[t][i*LB +: LB]};
        end else begin
          limb[t][i] = {1'b0, det_ext[t][i*LB +: LB]};
        end
        pp_nxt[t][i] = norm_i[t] * limb[t][i];
      end
    end
  end

  // recombine the limb products of each term
  always_comb begin
    for (int t = 0; t < 4; t++) begin
      term_nxt[t] = '0;
      for (int i = 0; i < NL; i++) begin
        term_nxt[t] = term_nxt[t] + (TW'(pp_r[t][i]) <<< (i*LB));
      end
    end
  end

  // insphere: -|b|^2 det(c,d,e) + |c|^2 det(b,d,e) - |d|^2 det(b,c,e) + |e|^2 det(b,c,d)
  always_comb begin
    if (tag6_r.func == FUNC_INSPHERE) begin
      val_nxt = RW'(term_r[1]) - RW'(term_r[0]) - RW'(term_r[2]) + RW'(term_r[3]);
    end else begin
      val_nxt = RW'(ori6_r);
    end
  end

  // sign and zero test
  always_comb begin
    if (val_r[RW-1]) begin
      sign_nxt = SIGN_NEG;
    end else if (|val_r) begin
      sign_nxt = SIGN_POS;
    end else begin
      sign_nxt = SIGN_ZERO;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag5_r <= '0;
      tag6_r <= '0;
      tag7_r <= '0;
      tag8_r <= '0;
    end else if (en) begin
      tag5_r <= tag_i;
      tag6_r <= tag5_r;
      tag7_r <= tag6_r;
      tag8_r <= tag7_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      pp_r   <= pp_nxt;
      ori5_r <= det_i[2];
      term_r <= term_nxt;
      ori6_r <= ori5_r;
      val_r  <= val_nxt;
      sign_r <= sign_nxt;
    end
  end

  assign tag_o  = tag8_r;
  assign sign_o = sign_r;

  // zero sign exactly when the summed value was zero
  `OIP_ASSERT_NEXT(a_zero_sign, clk, rst_n, en && tag7_r.vld, (sign_r == SIGN_ZERO) == ($past(val_r) == '0))

endmodule

FILE: hw/rtl/oip_obuf.sv
// output register with one skid entry; drives the pipeline advance
`include "orient_insphere_predicate_macros.svh"
module oip_obuf import oip_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  tag_t       tag_i,
  input  logic [1:0] sign_i,
  output logic       en_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_sign_o
);

  logic       take;
  logic       out_v_r;
  logic       out_v_nxt;
  logic [1:0] out_d_r;
  logic [1:0] out_d_nxt;
  logic       skid_v_r;
  logic       skid_v_nxt;
  logic [1:0] skid_d_r;
  logic [1:0] skid_d_nxt;

  // the pipeline moves only while the skid entry is free
  assign en_o = ~skid_v_r;
  assign take = tag_i.vld & ~skid_v_r;

  // output word and skid entry next state
  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (out_ready_i || !out_v_r) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = take;
        out_d_nxt = sign_i;
      end
    end else if (take) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = sign_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid_o = out_v_r;
  assign out_sign_o  = out_d_r;

  // the skid entry only fills behind a waiting output word
  `OIP_ASSERT_IMPL(a_skid_behind, clk, rst_n, skid_v_r, out_v_r)
  // a taken output word is replaced by the skid entry at once
  `OIP_ASSERT_NEXT(a_skid_drain, clk, rst_n, skid_v_r && out_ready_i, out_v_r && !skid_v_r)

endmodule

FILE: hw/rtl/orient_insphere_predicate.sv
// Exact 3D orientation / insphere sign unit. Each input word carries five
// packed points (x in the low field, then y, then z, each a signed
// COORD_BITS field; bits above three fields are ignored) and a func bit:
// 0 gives the sign of det(b-a, c-a, q-a), 1 the sign of the insphere
// determinant of tetrahedron a,b,c,d against q. All arithmetic is exact,
// so a degenerate configuration returns exactly zero (-1 is coded 2'b11).
// The unit takes one word per clock while the pipeline is not stalled;
// eight pipeline stages (differences, minors and squared lengths,
// cofactor products, determinants, limb products of the final multiply,
// limb recombination, term sum, sign) are followed by the output
// register. A stalled output freezes the pipeline once a one-entry skid
// buffer behind the output register has filled; no reset sweep is needed
// and there is no state kept between words.
module orient_insphere_predicate import oip_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [PT_W-1:0]   in_point_a,
  input  logic [PT_W-1:0]   in_point_b,
  input  logic [PT_W-1:0]   in_point_c,
  input  logic [PT_W-1:0]   in_point_d,
  input  logic [PT_W-1:0]   in_query_point,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [1:0] out_result_sign
);

  localparam int CB  = COORD_BITS;
  localparam int DW  = CB + 1;
  localparam int MW  = 2*CB + 3;
  localparam int DTW = 3*CB + 6;

  logic                  en;
  tag_t                  tag_in;
  tag_t                  tag2;
  tag_t                  tag4;
  tag_t                  tag8;
  logic [PT_W-1:0]       pts [5];
  logic signed [DW-1:0]  b_v [3];
  logic signed [DW-1:0]  c_v [3];
  logic signed [MW-1:0]  minor [3][3];
  logic signed [MW-1:0]  norm2 [4];
  logic signed [MW-1:0]  norm4 [4];
  logic signed [DTW-1:0] det [4];
  logic [1:0]            sign8;
  logic [1:0]            out_sign;

  // input word enters whenever the pipeline advances
  assign in_ready = en;
  assign tag_in   = '{vld: in_valid, func: in_func};
  assign pts[0]   = in_point_a;
  assign pts[1]   = in_point_b;
  assign pts[2]   = in_point_c;
  assign pts[3]   = in_point_d;
  assign pts[4]   = in_query_point;

  oip_minor #(.COORD_BITS(COORD_BITS)) u_minor (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .tag_i   (tag_in),
    .pt_i    (pts),
    .tag_o   (tag2),
    .b_o     (b_v),
    .c_o     (c_v),
    .minor_o (minor),
    .norm_o  (norm2)
  );

  oip_det #(.COORD_BITS(COORD_BITS)) u_det (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .tag_i   (tag2),
    .b_i     (b_v),
    .c_i     (c_v),
    .minor_i (minor),
    .norm_i  (norm2),
    .tag_o   (tag4),
    .det_o   (det),
    .norm_o  (norm4)
  );

  oip_scale #(.COORD_BITS(COORD_BITS)) u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .tag_i  (tag4),
    .det_i  (det),
    .norm_i (norm4),
    .tag_o  (tag8),
    .sign_o (sign8)
  );

  oip_obuf u_obuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .tag_i       (tag8),
    .sign_i      (sign8),
    .en_o        (en),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_sign_o  (out_sign)
  );

  assign out_result_sign = out_sign;

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the orient / insphere predicate unit
`timescale 1ns / 1ps

module tb_top;
  import oip_pkg::*;

  localparam int   COORD_W      = COORD_BITS_DEF;
  localparam int   STALL_LIMIT  = 2000;
  localparam int   DRAIN_CYCLES = 20;
  localparam int   RAND_PER_PHASE = 276;
  localparam logic FUNC_ORIENT  = 1'b0;

  typedef logic signed [127:0] acc_t;
  typedef struct { acc_t x, y, z; } vec3_t;
  typedef struct {
    logic            func;
    logic [PT_W-1:0] point_a;
    logic [PT_W-1:0] point_b;
    logic [PT_W-1:0] point_c;
    logic [PT_W-1:0] point_d;
    logic [PT_W-1:0] query_point;
  } word_t;

  // expected-sign store with its own exact determinant predictor
  class sign_scoreboard;
    logic [1:0] sign_q[$];
    int errors;
    int func_seen[2];
    int sign_seen[4];

    // signed coordinate k (0 x, 1 y, 2 z) of a packed point
    function acc_t coord_of(logic [PT_W-1:0] p, int k);
      logic signed [COORD_W-1:0] raw;
      raw = p[k*COORD_W +: COORD_W];
      return raw;
    endfunction

    function vec3_t offset(logic [PT_W-1:0] p, logic [PT_W-1:0] origin);
      vec3_t v;
      v.x = coord_of(p, 0) - coord_of(origin, 0);
      v.y = coord_of(p, 1) - coord_of(origin, 1);
      v.z = coord_of(p, 2) - coord_of(origin, 2);
      return v;
    endfunction

    function acc_t norm2(vec3_t v);
      return v.x * v.x + v.y * v.y + v.z * v.z;
    endfunction

    // determinant with u, v, t as rows
    function acc_t det3(vec3_t u, vec3_t v, vec3_t t);
      return u.x * (v.y * t.z - v.z * t.y)
           - u.y * (v.x * t.z - v.z * t.x)
           + u.z * (v.x * t.y - v.y * t.x);
    endfunction

    function logic [1:0] predicate_sign(word_t w);
      vec3_t vb, vc, vd, ve;
      acc_t  res;
      vb = offset(w.point_b, w.point_a);
      vc = offset(w.point_c, w.point_a);
      vd = offset(w.point_d, w.point_a);
      ve = offset(w.query_point, w.point_a);
      if (w.func == FUNC_INSPHERE) begin
        res = norm2(vc) * det3(vb, vd, ve) - norm2(vb) * det3(vc, vd, ve)
            - norm2(vd) * det3(vb, vc, ve) + norm2(ve) * det3(vb, vc, vd);
      end else begin
        res = det3(vb, vc, ve);
      end
      if (res < 0) begin
        return SIGN_NEG;
      end else if (res != 0) begin
        return SIGN_POS;
      end else begin
        return SIGN_ZERO;
      end
    endfunction

    function void note_word(word_t w);
      logic [1:0] s;
      s = predicate_sign(w);
      sign_q = {sign_q, s};
      func_seen[w.func]++;
      sign_seen[s]++;
    endfunction

    function void check_result(logic [1:0] got);
      logic [1:0] want;
      if (sign_q.size() == 0) begin
        $error("result_sign: no word outstanding, expected none, actual %0d", $signed(got));
        errors++;
      end else begin
        want = sign_q.pop_front();
        if (got !== want) begin
          $error("result_sign: expected %0d, actual %0d", $signed(want), $signed(got));
          errors++;
        end
      end
    endfunction

    function int pending();
      return sign_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_func = 1'b0;
  logic [PT_W-1:0]   in_point_a = '0;
  logic [PT_W-1:0]   in_point_b = '0;
  logic [PT_W-1:0]   in_point_c = '0;
  logic [PT_W-1:0]   in_point_d = '0;
  logic [PT_W-1:0]   in_query_point = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [1:0] out_result_sign;

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int stall_cycles = 0;
  sign_scoreboard sb;

  orient_insphere_predicate dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_point_a      (in_point_a),
    .in_point_b      (in_point_b),
    .in_point_c      (in_point_c),
    .in_point_d      (in_point_d),
    .in_query_point  (in_query_point),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_sign (out_result_sign)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= out_idle_pct);
  end

  // result check and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_result_sign);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  function automatic logic [PT_W-1:0] pack_pt(int x, int y, int z);
    return {z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
  endfunction

  function automatic int rnd_in(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic [PT_W-1:0] rnd_pt(int lim);
    return pack_pt(rnd_in(-lim, lim - 1), rnd_in(-lim, lim - 1), rnd_in(-lim, lim - 1));
  endfunction

  function automatic logic [PT_W-1:0] raw_pt();
    return {16'($urandom), $urandom};
  endfunction

  // point on the sphere around (cx,cy,cz) through permuted, sign-flipped offsets
  function automatic logic [PT_W-1:0] sphere_pt(int cx, int cy, int cz,
                                                 int r0, int r1, int r2);
    int v[3];
    int i, j, t;
    v[0] = r0;
    v[1] = r1;
    v[2] = r2;
    repeat (2) begin
      i = $urandom_range(2);
      j = $urandom_range(2);
      t = v[i];
      v[i] = v[j];
      v[j] = t;
    end
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(1)) v[k] = -v[k];
    end
    return pack_pt(cx + v[0], cy + v[1], cz + v[2]);
  endfunction

  function automatic word_t make_word(logic func, logic [PT_W-1:0] a, logic [PT_W-1:0] b,
                                      logic [PT_W-1:0] c, logic [PT_W-1:0] d,
                                      logic [PT_W-1:0] q);
    word_t w;
    w.func = func;
    w.point_a = a;
    w.point_b = b;
    w.point_c = c;
    w.point_d = d;
    w.query_point = q;
    return w;
  endfunction

  // random word: full range, scaled ranges, cospherical, coplanar, repeated points
  function automatic word_t gen_word();
    word_t w;
    int kind, lim, cx, cy, cz, r0, r1, r2, s, t;
    int pa[3], pb[3], pc[3], pq[3];
    w = make_word(logic'($urandom_range(1)), raw_pt(), raw_pt(), raw_pt(), raw_pt(), raw_pt());
    kind = $urandom_range(9);
    case (kind)
      3: begin
        w.point_a = rnd_pt(4);
        w.point_b = rnd_pt(4);
        w.point_c = rnd_pt(4);
        w.point_d = rnd_pt(4);
        w.query_point = rnd_pt(4);
      end
      4, 5: begin
        lim = 1 << $urandom_range(1, 15);
        w.point_a = rnd_pt(lim);
        w.point_b = rnd_pt(lim);
        w.point_c = rnd_pt(lim);
        w.point_d = rnd_pt(lim);
        w.query_point = rnd_pt(lim);
      end
      6, 7: begin
        w.func = FUNC_INSPHERE;
        cx = rnd_in(-12000, 12000);
        cy = rnd_in(-12000, 12000);
        cz = rnd_in(-12000, 12000);
        r0 = rnd_in(0, 20000);
        r1 = rnd_in(0, 20000);
        r2 = rnd_in(0, 20000);
        w.point_a = sphere_pt(cx, cy, cz, r0, r1, r2);
        w.point_b = sphere_pt(cx, cy, cz, r0, r1, r2);
        w.point_c = sphere_pt(cx, cy, cz, r0, r1, r2);
        w.point_d = sphere_pt(cx, cy, cz, r0, r1, r2);
        w.query_point = sphere_pt(cx, cy, cz, r0, r1, r2);
        // nudge off the sphere now and then
        if ($urandom_range(3) == 0) w.query_point[0] = ~w.query_point[0];
      end
      8: begin
        if ($urandom_range(3) != 0) w.func = FUNC_ORIENT;
        for (int k = 0; k < 3; k++) begin
          pa[k] = rnd_in(-5000, 5000);
          pb[k] = rnd_in(-5000, 5000);
          pc[k] = rnd_in(-5000, 5000);
        end
        s = rnd_in(-1, 1);
        t = rnd_in(-1, 1);
        for (int k = 0; k < 3; k++) begin
          pq[k] = pa[k] + s * (pb[k] - pa[k]) + t * (pc[k] - pa[k]);
        end
        if ($urandom_range(3) == 0) pq[$urandom_range(2)] += 1;
        w.point_a = pack_pt(pa[0], pa[1], pa[2]);
        w.point_b = pack_pt(pb[0], pb[1], pb[2]);
        w.point_c = pack_pt(pc[0], pc[1], pc[2]);
        w.query_point = pack_pt(pq[0], pq[1], pq[2]);
      end
      9: begin
        case ($urandom_range(3))
          0: w.query_point = w.point_a;
          1: w.query_point = w.point_b;
          2: w.point_c = w.point_b;
          default: w.point_d = w.point_a;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  // present one word and hold it until accepted
  task automatic send_word(word_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_func        <= w.func;
    in_point_a     <= w.point_a;
    in_point_b     <= w.point_b;
    in_point_c     <= w.point_c;
    in_point_d     <= w.point_d;
    in_query_point <= w.query_point;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    @(negedge clk);
  endtask

  // extremes, both operations, ignored d, degenerate geometry
  task automatic run_directed();
    logic [PT_W-1:0] o, ex, ey, ez, nx, ny, nz, lo, hi, cx, cy, cz, ones, alt;
    o    = pack_pt(0, 0, 0);
    ex   = pack_pt(1, 0, 0);
    ey   = pack_pt(0, 1, 0);
    ez   = pack_pt(0, 0, 1);
    nx   = pack_pt(-1, 0, 0);
    ny   = pack_pt(0, -1, 0);
    nz   = pack_pt(0, 0, -1);
    lo   = pack_pt(-32768, -32768, -32768);
    hi   = pack_pt(32767, 32767, 32767);
    cx   = pack_pt(32767, -32768, -32768);
    cy   = pack_pt(-32768, 32767, -32768);
    cz   = pack_pt(-32768, -32768, 32767);
    ones = {PT_W{1'b1}};
    alt  = 48'hAAAA_AAAA_AAAA;
    // orientation
    send_word(make_word(FUNC_ORIENT, o, o, o, o, o));
    send_word(make_word(FUNC_ORIENT, o, ex, ey, o, ez));
    send_word(make_word(FUNC_ORIENT, o, ex, ey, o, nz));
    send_word(make_word(FUNC_ORIENT, o, ex, ey, ones, ez));
    send_word(make_word(FUNC_ORIENT, o, ex, ey, 48'h8000_8000_8000, ez));
    send_word(make_word(FUNC_ORIENT, lo, cx, cy, hi, cz));
    send_word(make_word(FUNC_ORIENT, lo, cy, cx, hi, cz));
    send_word(make_word(FUNC_ORIENT, lo, cx, cy, o, pack_pt(0, 0, -32768)));
    send_word(make_word(FUNC_ORIENT, o, ex, ey, o, pack_pt(5, 7, 0)));
    send_word(make_word(FUNC_ORIENT, ones, ones, ones, ones, ones));
    send_word(make_word(FUNC_ORIENT, alt, ~alt, 48'h5555_AAAA_5555, alt,
                        48'h7FFF_8000_0001));
    // insphere
    send_word(make_word(FUNC_INSPHERE, ones, ones, ones, ones, ones));
    send_word(make_word(FUNC_INSPHERE, ex, ey, ez, nx, o));
    send_word(make_word(FUNC_INSPHERE, ex, ey, ez, nx, hi));
    send_word(make_word(FUNC_INSPHERE, ex, ey, ez, nx, ny));
    send_word(make_word(FUNC_INSPHERE, ex, ez, ey, nx, o));
    send_word(make_word(FUNC_INSPHERE, lo, cx, cy, cz, hi));
    send_word(make_word(FUNC_INSPHERE, lo, cx, cy, cz, o));
    send_word(make_word(FUNC_INSPHERE, lo, cx, cy, cz, lo));
    send_word(make_word(FUNC_INSPHERE, hi, lo, cx, cy, cz));
    send_word(make_word(FUNC_INSPHERE, alt, ~alt, 48'h5555_AAAA_5555,
                        48'hAAAA_5555_AAAA, 48'h7FFF_8000_0001));
    send_word(make_word(FUNC_INSPHERE, o, ex, ey, pack_pt(1, 1, 0), ez));
  endtask

  initial begin
    sb = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // sender mostly busy, receiver stalling often
    in_idle_pct  = 13;
    out_idle_pct = 64;
    run_directed();
    repeat (RAND_PER_PHASE) send_word(gen_word());

    // sender sparse, receiver mostly ready
    in_idle_pct  = 64;
    out_idle_pct = 13;
    repeat (RAND_PER_PHASE) send_word(gen_word());

    // full rate both sides
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (RAND_PER_PHASE) send_word(gen_word());
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d orientation and %0d insphere words over three idle patterns",
             sb.func_seen[0], sb.func_seen[1]);
    $display("expected signs negative/zero/positive: %0d/%0d/%0d",
             sb.sign_seen[SIGN_NEG], sb.sign_seen[SIGN_ZERO], sb.sign_seen[SIGN_POS]);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
